### sv/tbac_pkg.sv
// Shared types and constants for the token bucket admission control block.
package tbac_pkg;

  // Default number of channel cells
  localparam int CHANNELS_DEF = 64;
  // Width of the channel count register and its value after reset
  localparam int CNT_W        = 7;
  localparam int CNT_RESET    = 64;

  typedef enum logic [1:0] {
    CMD_ENQ    = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_CFG    = 2'd2,
    CMD_SETGAS = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BUSY = 2'd1,
    ST_DROP = 2'd2,
    ST_EXH  = 2'd3
  } status_e;

  // Item travelling down the cell chain
  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] channel;
    logic [31:0] cost;
    logic [15:0] depth_limit;
    logic [31:0] bucket_limit;
    logic [31:0] refill_rate;
    status_e     status;
  } tok_t;

endpackage

### sv/tbac_cell.sv
// One channel cell: holds the channel's bucket and depth state and forwards the item.
module tbac_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [tbac_pkg::CNT_W-1:0]   cnt_i,
  input  logic                         vld_i,
  input  tbac_pkg::tok_t               tok_i,
  output logic                         vld_o,
  output tbac_pkg::tok_t               tok_o
);
  import tbac_pkg::*;

  logic [15:0] dlim_q, dlim_d;
  logic [15:0] depth_q, depth_d;
  logic [31:0] blim_q, blim_d;
  logic [31:0] bkt_q, bkt_d;
  logic [31:0] refill_q, refill_d;
  logic        vld_q;
  tok_t        tok_q, tok_d;

  logic        match;
  logic        active;
  logic [32:0] sum;

  assign match  = (tok_i.channel == 16'(CELL_IDX));
  assign active = (CELL_IDX < int'(cnt_i));
  assign sum    = {1'b0, bkt_q} + {1'b0, refill_q};

  // Apply the item to this channel as it passes
  always_comb begin
    dlim_d   = dlim_q;
    depth_d  = depth_q;
    blim_d   = blim_q;
    bkt_d    = bkt_q;
    refill_d = refill_q;
    tok_d    = tok_i;
    if (vld_i) begin
      unique case (tok_i.cmd)
        CMD_ENQ: begin
          if (match && tok_i.status == ST_OK) begin
            if (dlim_q != 16'd0 && depth_q >= dlim_q) begin
              tok_d.status = ST_BUSY;
            end else if (tok_i.cost > bkt_q) begin
              tok_d.status = ST_DROP;
            end else begin
              bkt_d = bkt_q - tok_i.cost;
              if (dlim_q != 16'd0) depth_d = depth_q + 16'd1;
            end
          end
        end
        CMD_TICK: begin
          if (active) begin
            // refill saturates at the bucket capacity
            if (bkt_q < blim_q) begin
              bkt_d = (sum > {1'b0, blim_q}) ? blim_q : sum[31:0];
            end
            if (depth_q != 16'd0) depth_d = depth_q - 16'd1;
          end
        end
        CMD_CFG: begin
          if (match && tok_i.status == ST_OK) begin
            dlim_d   = tok_i.depth_limit;
            depth_d  = 16'd0;
            blim_d   = tok_i.bucket_limit;
            bkt_d    = tok_i.bucket_limit;
            refill_d = tok_i.refill_rate;
          end
        end
        CMD_SETGAS: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dlim_q   <= '0;
      depth_q  <= '0;
      blim_q   <= '0;
      bkt_q    <= '0;
      refill_q <= '0;
      vld_q    <= 1'b0;
    end else begin
      dlim_q   <= dlim_d;
      depth_q  <= depth_d;
      blim_q   <= blim_d;
      bkt_q    <= bkt_d;
      refill_q <= refill_d;
      vld_q    <= vld_i;
    end
  end

  // Item payload to the next cell
  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign vld_o = vld_q;
  assign tok_o = tok_q;

endmodule

### sv/token_bucket_admission_control.sv
// Top level: command intake, global budget and the chain of channel cells.
//
//  Channel   Handshake              Fields
//  command   start / busy           cmd_i channel_i cost_i depth_limit_i
//                                   bucket_limit_i refill_rate_i gas_value_i
//  result    done_o strobe          status_o remaining_gas_o
//  config    cfg_we_i               cfg_data_i (channel count)
//
// An item walks the row of CHANNELS cells, through the entry register and each
// cell's register, and then the result register; busy drops in the strobe
// cycle, so a new item is taken only once the last one has left the chain.
// Reset clears every channel, the budget, and sets the channel count to 64 or CHANNELS, whichever is smaller.
// The result is shown for one cycle only; the receiver cannot stall it.
module token_bucket_admission_control #(
  parameter int CHANNELS = tbac_pkg::CHANNELS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 cmd_i,
  input  logic [15:0]                channel_i,
  input  logic [31:0]                cost_i,
  input  logic [15:0]                depth_limit_i,
  input  logic [31:0]                bucket_limit_i,
  input  logic [31:0]                refill_rate_i,
  input  logic [31:0]                gas_value_i,
  input  logic                       cfg_we_i,
  input  logic [tbac_pkg::CNT_W-1:0] cfg_data_i,
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic [31:0]                remaining_gas_o
);
  import tbac_pkg::*;

  localparam int CntRst = (CNT_RESET > CHANNELS) ? CHANNELS : CNT_RESET;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q;
  logic [31:0]       gas_q, gas_d;
  logic [31:0]       gval_q;
  logic              in_vld_q;
  tok_t              in_tok_q, in_tok_d;
  logic              done_q;
  status_e           status_q;

  logic              accept;
  logic              in_range;
  cmd_e              cmd;
  logic              exit_vld;
  tok_t              exit_tok;

  logic              vld_w [CHANNELS+1];
  tok_t              tok_w [CHANNELS+1];

  assign cmd      = cmd_e'(cmd_i);
  assign accept   = start && (state_q == S_IDLE);
  assign in_range = (channel_i < 16'(cnt_q));

  // Build the entry item, with the range and budget checks done up front
  always_comb begin
    in_tok_d.cmd          = cmd;
    in_tok_d.channel      = channel_i;
    in_tok_d.cost         = cost_i;
    in_tok_d.depth_limit  = depth_limit_i;
    in_tok_d.bucket_limit = bucket_limit_i;
    in_tok_d.refill_rate  = refill_rate_i;
    in_tok_d.status       = ST_OK;
    unique case (cmd)
      CMD_ENQ: begin
        if (!in_range)           in_tok_d.status = ST_DROP;
        else if (cost_i > gas_q) in_tok_d.status = ST_EXH;
      end
      CMD_CFG: begin
        if (!in_range) in_tok_d.status = ST_DROP;
      end
      CMD_TICK, CMD_SETGAS: begin
      end
      default: begin
      end
    endcase
  end

  // Cell chain
  assign vld_w[0] = in_vld_q;
  assign tok_w[0] = in_tok_q;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
    tbac_cell #(
      .CELL_IDX(g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .cnt_i (cnt_q),
      .vld_i (vld_w[g]),
      .tok_i (tok_w[g]),
      .vld_o (vld_w[g+1]),
      .tok_o (tok_w[g+1])
    );
  end

  assign exit_vld = vld_w[CHANNELS];
  assign exit_tok = tok_w[CHANNELS];

  // Budget update when the item leaves the chain
  always_comb begin
    gas_d = gas_q;
    if (exit_vld) begin
      if (exit_tok.cmd == CMD_ENQ && exit_tok.status == ST_OK) begin
        gas_d = gas_q - exit_tok.cost;
      end else if (exit_tok.cmd == CMD_SETGAS) begin
        gas_d = gval_q;
      end
    end
  end

  // Control FSM
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_RUN;
      S_RUN:   if (exit_vld) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= CNT_W'(CntRst);
      gas_q    <= '0;
      in_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      gas_q    <= gas_d;
      in_vld_q <= accept;
      done_q   <= exit_vld;
      if (cfg_we_i) begin
        cnt_q <= (int'(cfg_data_i) > CHANNELS) ? CNT_W'(CHANNELS) : cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_tok_q <= in_tok_d;
      gval_q   <= gas_value_i;
    end
    if (exit_vld) status_q <= exit_tok.status;
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign remaining_gas_o = gas_q;

endmodule

### dv/token_bucket_admission_control_test.sv
// Self-checking testbench for the token bucket admission control block.
module token_bucket_admission_control_test;
  import tbac_pkg::*;

  localparam int NCH = CHANNELS_DEF;

  // One command as it sits on the input ports
  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] channel;
    logic [31:0] cost;
    logic [15:0] depth_limit;
    logic [31:0] bucket_limit;
    logic [31:0] refill_rate;
    logic [31:0] gas_value;
  } command_t;

  // Expected answer to one command
  typedef struct packed {
    status_e     status;
    logic [31:0] gas;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  cmd_i = '0;
  logic [15:0] channel_i = '0;
  logic [31:0] cost_i = '0;
  logic [15:0] depth_limit_i = '0;
  logic [31:0] bucket_limit_i = '0;
  logic [31:0] refill_rate_i = '0;
  logic [31:0] gas_value_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [CNT_W-1:0] cfg_data_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [31:0] remaining_gas_o;

  token_bucket_admission_control dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .cmd_i           (cmd_i),
    .channel_i       (channel_i),
    .cost_i          (cost_i),
    .depth_limit_i   (depth_limit_i),
    .bucket_limit_i  (bucket_limit_i),
    .refill_rate_i   (refill_rate_i),
    .gas_value_i     (gas_value_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .remaining_gas_o (remaining_gas_o)
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the channel tables and the shared budget
  logic [15:0] depth_cap [NCH];
  logic [15:0] in_flight [NCH];
  logic [31:0] capacity [NCH];
  logic [31:0] tokens [NCH];
  logic [31:0] refill [NCH];
  logic [31:0] budget = '0;
  int unsigned chan_count = CNT_RESET;

  command_t cmd_backlog[$];
  reply_t   pending_replies[$];
  int       queued_cnt = 0;
  int       accepted_cnt = 0;
  int       errors = 0;
  bit       took = 1'b0;
  bit       quiet = 1'b0;
  int       gap_left = 0;
  bit       gap_on_idle = 1'b0;
  logic     start_nxt;
  command_t cur;

  initial begin
    for (int i = 0; i < NCH; i++) begin
      depth_cap[i] = '0;
      in_flight[i] = '0;
      capacity[i] = '0;
      tokens[i] = '0;
      refill[i] = '0;
    end
  end

  // Apply one command to the shadow state and return the expected answer
  function automatic reply_t admit_command(command_t c);
    reply_t      r;
    int unsigned ch;
    logic [32:0] sum;
    r.status = ST_OK;
    ch = c.channel;
    case (c.cmd)
      CMD_ENQ: begin
        if (ch >= chan_count) r.status = ST_DROP;
        else if (c.cost > budget) r.status = ST_EXH;
        else if (depth_cap[ch] != 0 && in_flight[ch] >= depth_cap[ch]) r.status = ST_BUSY;
        else if (c.cost > tokens[ch]) r.status = ST_DROP;
        else begin
          budget = budget - c.cost;
          tokens[ch] = tokens[ch] - c.cost;
          if (depth_cap[ch] != 0) in_flight[ch] = in_flight[ch] + 16'd1;
        end
      end
      CMD_TICK: begin
        for (int i = 0; i < NCH; i++) begin
          if (i < chan_count) begin
            if (tokens[i] < capacity[i]) begin
              sum = {1'b0, tokens[i]} + {1'b0, refill[i]};
              tokens[i] = (sum > {1'b0, capacity[i]}) ? capacity[i] : sum[31:0];
            end
            if (in_flight[i] != 0) in_flight[i] = in_flight[i] - 16'd1;
          end
        end
      end
      CMD_CFG: begin
        if (ch >= chan_count) r.status = ST_DROP;
        else begin
          depth_cap[ch] = c.depth_limit;
          in_flight[ch] = '0;
          capacity[ch] = c.bucket_limit;
          tokens[ch] = c.bucket_limit;
          refill[ch] = c.refill_rate;
        end
      end
      default: budget = c.gas_value;
    endcase
    r.gas = budget;
    return r;
  endfunction

  // Acceptance and result checking at the rising edge
  always @(posedge clk_i) begin
    command_t c;
    reply_t   want;
    took = 1'b0;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_replies.size() == 0) begin
          if (errors < 10)
            $display("unexpected result: status %0d gas %0h", status_o, remaining_gas_o);
          errors++;
        end else begin
          want = pending_replies.pop_front();
          if (status_o !== want.status) begin
            if (errors < 10)
              $display("status mismatch: expected %0d got %0d", want.status, status_o);
            errors++;
          end
          if (remaining_gas_o !== want.gas) begin
            if (errors < 10)
              $display("remaining gas mismatch: expected %0h got %0h", want.gas,
                       remaining_gas_o);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        took = 1'b1;
        accepted_cnt++;
        c.cmd = cmd_e'(cmd_i);
        c.channel = channel_i;
        c.cost = cost_i;
        c.depth_limit = depth_limit_i;
        c.bucket_limit = bucket_limit_i;
        c.refill_rate = refill_rate_i;
        c.gas_value = gas_value_i;
        pending_replies.push_back(admit_command(c));
      end
    end
  end

  // Command driver: holds start until the item is taken, then maybe idles
  always @(negedge clk_i) begin
    if (rst_ni) begin
      start_nxt = start;
      if (start && took) begin
        start_nxt = 1'b0;
        if (!quiet && $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(1, 9);
          gap_on_idle = $urandom_range(0, 1);
        end
      end
      if (!start_nxt) begin
        if (gap_left > 0) begin
          // some bursts only count cycles where the block is free
          if (!gap_on_idle || !busy) gap_left--;
        end else if (cmd_backlog.size() > 0) begin
          cur = cmd_backlog.pop_front();
          cmd_i <= cur.cmd;
          channel_i <= cur.channel;
          cost_i <= cur.cost;
          depth_limit_i <= cur.depth_limit;
          bucket_limit_i <= cur.bucket_limit;
          refill_rate_i <= cur.refill_rate;
          gas_value_i <= cur.gas_value;
          start_nxt = 1'b1;
        end
      end
      start <= start_nxt;
    end
  end

  // Build a command; unused fields carry random junk
  function automatic command_t mk(cmd_e op, int unsigned ch, logic [31:0] a,
                                  logic [31:0] b, logic [31:0] r);
    command_t c;
    c.cmd = op;
    c.channel = ch[15:0];
    c.cost = $urandom;
    c.depth_limit = 16'($urandom);
    c.bucket_limit = $urandom;
    c.refill_rate = $urandom;
    c.gas_value = $urandom;
    case (op)
      CMD_ENQ: c.cost = a;
      CMD_CFG: begin
        c.depth_limit = a[15:0];
        c.bucket_limit = b;
        c.refill_rate = r;
      end
      CMD_SETGAS: c.gas_value = a;
      default: ;
    endcase
    return c;
  endfunction

  task automatic send(command_t c);
    cmd_backlog.push_back(c);
    queued_cnt++;
  endtask

  function automatic int unsigned pick_channel();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) return $urandom_range(0, (chan_count == 0) ? NCH - 1 : chan_count - 1);
    if (sel < 90) return $urandom_range(0, 127);
    return $urandom_range(0, 65535);
  endfunction

  function automatic command_t random_command();
    int unsigned sel;
    int unsigned pick;
    logic [31:0] dl, bl, rr, v;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      pick = $urandom_range(0, 99);
      v = (pick < 10) ? 32'd0 : (pick < 85) ? $urandom_range(0, 400) : $urandom;
      return mk(CMD_ENQ, pick_channel(), v, '0, '0);
    end
    if (sel < 75) return mk(CMD_TICK, $urandom_range(0, 65535), '0, '0, '0);
    if (sel < 90) begin
      pick = $urandom_range(0, 9);
      dl = (pick < 3) ? 32'd0 : (pick < 8) ? $urandom_range(1, 4) : $urandom;
      bl = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 2000);
      pick = $urandom_range(0, 19);
      rr = (pick < 3) ? 32'd0 : (pick < 17) ? $urandom_range(0, 500) : $urandom;
      return mk(CMD_CFG, pick_channel(), dl, bl, rr);
    end
    pick = $urandom_range(0, 19);
    v = (pick < 14) ? $urandom_range(0, 50000) : (pick < 17) ? $urandom : 32'hFFFF_FFFF;
    return mk(CMD_SETGAS, $urandom_range(0, 65535), v, '0, '0);
  endfunction

  // Budget refill and a few configured channels, then a random mix
  task automatic run_phase(int n);
    int setup;
    setup = (chan_count < 8) ? chan_count : 8;
    send(mk(CMD_SETGAS, 0, $urandom_range(100000, 1000000), '0, '0));
    for (int i = 0; i < setup; i++)
      send(mk(CMD_CFG, $urandom_range(0, chan_count - 1), $urandom_range(0, 4),
              $urandom_range(200, 2000), $urandom_range(10, 400)));
    for (int i = setup + 1; i < n; i++) send(random_command());
  endtask

  // Wait until every item is taken and answered, then let the clock run on
  task automatic drain();
    while (accepted_cnt != queued_cnt || pending_replies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_channel_count(int unsigned v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v[CNT_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    chan_count = (v > NCH) ? NCH : v;
  endtask

  // Main sequence
  initial begin
    int unsigned counts [6];
    int          sizes [6];
    counts = '{0, 127, 1, 65, 37, 64};
    sizes = '{50, 250, 100, 250, 300, 330};
    counts[4] = $urandom_range(2, 63);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty budget, range checks, depth, bucket and refill limits
    send(mk(CMD_ENQ, 0, 32'd0, '0, '0));
    send(mk(CMD_ENQ, 0, 32'd1, '0, '0));
    send(mk(CMD_SETGAS, 0, 32'hFFFF_FFFF, '0, '0));
    send(mk(CMD_ENQ, 64, 32'd0, '0, '0));
    send(mk(CMD_ENQ, 16'hFFFF, 32'd0, '0, '0));
    send(mk(CMD_CFG, 16'hFFFF, 32'd1, 32'd1, 32'd1));
    send(mk(CMD_CFG, 0, 32'd2, 32'd100, 32'd30));
    send(mk(CMD_ENQ, 0, 32'd60, '0, '0));
    send(mk(CMD_ENQ, 0, 32'd40, '0, '0));
    send(mk(CMD_ENQ, 0, 32'd0, '0, '0));
    send(mk(CMD_TICK, 0, '0, '0, '0));
    send(mk(CMD_ENQ, 0, 32'd31, '0, '0));
    send(mk(CMD_ENQ, 0, 32'd30, '0, '0));
    send(mk(CMD_CFG, 63, 32'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send(mk(CMD_ENQ, 63, 32'hFFFF_FFFF, '0, '0));
    send(mk(CMD_SETGAS, 0, 32'hFFFF_FFFF, '0, '0));
    send(mk(CMD_ENQ, 63, 32'hFFFF_FFFF, '0, '0));
    send(mk(CMD_CFG, 1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send(mk(CMD_SETGAS, 0, 32'd10, '0, '0));
    send(mk(CMD_ENQ, 1, 32'd1, '0, '0));
    send(mk(CMD_TICK, 0, '0, '0, '0));
    send(mk(CMD_CFG, 5, 32'd0, 32'd0, 32'd0));
    send(mk(CMD_ENQ, 5, 32'd0, '0, '0));
    send(mk(CMD_SETGAS, 0, 32'd0, '0, '0));
    send(mk(CMD_ENQ, 1, 32'd0, '0, '0));
    drain();

    // random phases under several channel counts, idle-free at the end
    for (int p = 0; p < 6; p++) begin
      write_channel_count(counts[p]);
      if (p == 5) quiet = 1'b1;
      run_phase(sizes[p]);
      drain();
    end

    repeat (NCH + 4) @(posedge clk_i);
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("** token_bucket_admission_control: PASSED **");
    end else begin
      $display("** token_bucket_admission_control: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #6400000;
    $display("** token_bucket_admission_control: FAILED **");
    $finish;
  end

endmodule
